FILE: rtl/core/ctfc_pkg.sv
// Package: types, constants and lookup functions for the clock tree frequency calculator.
`default_nettype none

package ctfc_pkg;

  localparam int FREQ_W     = 32;
  localparam int ADC_W      = 31;
  localparam int XTAL_W     = 25;
  localparam int MUL_W      = 6;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 224;

  // Pipelined divider geometry
  localparam int DIV_W      = 32;
  localparam int DEN_W      = 5;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  localparam logic [FREQ_W-1:0] HSI_HZ      = FREQ_W'(8000000);
  localparam logic [FREQ_W-1:0] HSI_HALF_HZ = FREQ_W'(4000000);
  localparam logic [XTAL_W-1:0] XTAL_RESET  = XTAL_W'(8000000);

  localparam logic [3:0] AHB_DIV_MASK = 4'h8;
  localparam logic [3:0] AHB_LOW_MASK = 4'h7;
  localparam logic [3:0] AHB_GAP_MASK = 4'h4;
  localparam logic [2:0] APB_DIV_MASK = 3'h4;
  localparam logic [2:0] APB_LOW_MASK = 3'h3;

  typedef enum logic [1:0] {
    SW_HSI  = 2'd0,
    SW_HSE  = 2'd1,
    SW_PLL  = 2'd2,
    SW_NONE = 2'd3
  } sw_t;

  // Input transaction, last field in the low bits
  typedef struct packed {
    logic [6:0] pad;
    logic [1:0] adc_prescale_code;
    logic [2:0] apb2_prescale_code;
    logic [2:0] apb1_prescale_code;
    logic [3:0] ahb_prescale_code;
    logic       internal_full_rate;
    logic [3:0] pll_mul_code;
    logic [3:0] prediv1_code;
    logic [3:0] pll2_mul_code;
    logic [3:0] prediv2_code;
    logic       prediv1_from_pll2;
    logic       pll_from_prediv1;
    logic [1:0] switch_status;
  } query_t;

  // Result transaction, last field in the low bits
  typedef struct packed {
    logic              pad;
    logic [ADC_W-1:0]  adc_freq;
    logic [FREQ_W-1:0] apb2_timer_freq;
    logic [FREQ_W-1:0] apb2_freq;
    logic [FREQ_W-1:0] apb1_timer_freq;
    logic [FREQ_W-1:0] apb1_freq;
    logic [FREQ_W-1:0] ahb_freq;
    logic [FREQ_W-1:0] system_freq;
  } result_t;

  // Context that travels down the pipeline next to the arithmetic
  typedef struct packed {
    sw_t               sw;
    logic              pll_from_prediv1;
    logic              prediv1_from_pll2;
    logic [3:0]        pll2_mul_code;
    logic [3:0]        prediv1_code;
    logic [3:0]        pll_mul_code;
    logic              internal_full_rate;
    logic [3:0]        ahb_code;
    logic [2:0]        apb1_code;
    logic [2:0]        apb2_code;
    logic [1:0]        adc_code;
    logic [XTAL_W-1:0] xtal;
    logic [FREQ_W-1:0] sys;
    logic [FREQ_W-1:0] ahb;
    logic [FREQ_W-1:0] apb1;
    logic [FREQ_W-1:0] apb1t;
    logic [FREQ_W-1:0] apb2;
    logic [FREQ_W-1:0] apb2t;
  } ctx_t;

  function automatic logic [MUL_W-1:0] main_mul_half(input logic [3:0] code);
    logic [MUL_W-1:0] m;
    unique case (code)
      4'd0:  m = 6'd36;
      4'd1:  m = 6'd6;
      4'd2:  m = 6'd8;
      4'd3:  m = 6'd10;
      4'd4:  m = 6'd12;
      4'd5:  m = 6'd14;
      4'd6:  m = 6'd16;
      4'd7:  m = 6'd18;
      4'd8:  m = 6'd20;
      4'd9:  m = 6'd22;
      4'd10: m = 6'd24;
      4'd11: m = 6'd26;
      4'd12: m = 6'd28;
      4'd13: m = 6'd13;
      4'd14: m = 6'd30;
      4'd15: m = 6'd32;
    endcase
    return m;
  endfunction

  function automatic logic [MUL_W-1:0] pll2_mul_half(input logic [3:0] code);
    logic [MUL_W-1:0] m;
    unique case (code)
      4'd0:  m = 6'd5;
      4'd1:  m = 6'd25;
      4'd2:  m = 6'd8;
      4'd3:  m = 6'd10;
      4'd4:  m = 6'd12;
      4'd5:  m = 6'd14;
      4'd6:  m = 6'd16;
      4'd7:  m = 6'd18;
      4'd8:  m = 6'd20;
      4'd9:  m = 6'd22;
      4'd10: m = 6'd24;
      4'd11: m = 6'd26;
      4'd12: m = 6'd28;
      4'd13: m = 6'd30;
      4'd14: m = 6'd32;
      4'd15: m = 6'd40;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] low;
    low = code & AHB_LOW_MASK;
    if ((code & AHB_DIV_MASK) == 4'd0) begin
      return 4'd0;
    end
    return ((low & AHB_GAP_MASK) != 4'd0) ? low + 4'd2 : low + 4'd1;
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    return ((code & APB_DIV_MASK) != 3'd0) ? (code & APB_LOW_MASK) + 3'd1 : 3'd0;
  endfunction

  function automatic logic [2:0] apb_timer_shift(input logic [2:0] code);
    return ((code & APB_DIV_MASK) != 3'd0) ? (code & APB_LOW_MASK) : 3'd0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/clock_tree_frequency_calc.sv
// Top level: clock tree frequency calculator, crystal register, PLL stages and output buffer.
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ----------------------------------------------
//  s_*       in   s_tvalid/s_tready  s_tdata[39:0]   decoded clock-control fields
//  m_*       out  m_tvalid/m_tready  m_tdata[223:0]  seven derived frequencies
//  cfg_*     in   cfg_we             cfg_wdata[24:0] crystal frequency in hertz
//
//  One transaction enters per cycle while s_tready is high. The path from acceptance to
//  m_tdata runs through three 8-stage dividers (prediv2, prediv1, ADC), two multiply stages,
//  two prescaler stages and the output register.
//  Synchronous rst empties the pipeline and loads the crystal register with 8 MHz.
//  With m_tready low the result holds; one more result parks in the skid stage and
//  s_tready then drops until the skid drains. No transaction is lost or repeated.
`default_nettype none

module clock_tree_frequency_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // switch_status[1:0], pll_from_prediv1[2], prediv1_from_pll2[3], prediv2_code[7:4],
  // pll2_mul_code[11:8], prediv1_code[15:12], pll_mul_code[19:16],
  // internal_full_rate[20], ahb_prescale_code[24:21], apb1_prescale_code[27:25],
  // apb2_prescale_code[30:28], adc_prescale_code[32:31], zero[39:33]
  input  logic [ctfc_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // system_freq[31:0], ahb_freq[63:32], apb1_freq[95:64], apb1_timer_freq[127:96],
  // apb2_freq[159:128], apb2_timer_freq[191:160], adc_freq[222:192], zero[223]
  output logic [ctfc_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_we,
  input  logic [ctfc_pkg::XTAL_W-1:0]   cfg_wdata
);
  import ctfc_pkg::*;

  logic [XTAL_W-1:0] crystal_freq_hz;
  logic              pipe_en;
  query_t            q;
  ctx_t              ctx0;

  logic              d1_valid;
  logic [DIV_W-1:0]  d1_quo;
  ctx_t              d1_ctx;

  logic              m1_valid;
  logic [DIV_W-1:0]  m1_num;
  ctx_t              m1_ctx;
  logic [DIV_W-1:0]  m1_num_next;
  logic [FREQ_W-1:0] pll2_prod;

  logic              d2_valid;
  logic [DIV_W-1:0]  d2_quo;
  ctx_t              d2_ctx;

  logic              m2_valid;
  ctx_t              m2_ctx;
  ctx_t              m2_ctx_next;
  logic [FREQ_W-1:0] pll_base;
  logic [FREQ_W-1:0] pll_prod;

  logic              ps_valid;
  ctx_t              ps_ctx;

  logic              d3_valid;
  logic [DIV_W-1:0]  d3_quo;
  ctx_t              d3_ctx;
  result_t           res;
  result_t           m_res;

  // Crystal frequency register; unchecked user rule: written only while pipeline is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_freq_hz <= XTAL_RESET;
    end else if (cfg_we) begin
      crystal_freq_hz <= cfg_wdata;
    end
  end

  assign q        = query_t'(s_tdata);
  assign s_tready = pipe_en;

  // Unpack the query and latch the crystal value with it
  always_comb begin
    ctx0                    = '0;
    ctx0.sw                 = sw_t'(q.switch_status);
    ctx0.pll_from_prediv1   = q.pll_from_prediv1;
    ctx0.prediv1_from_pll2  = q.prediv1_from_pll2;
    ctx0.pll2_mul_code      = q.pll2_mul_code;
    ctx0.prediv1_code       = q.prediv1_code;
    ctx0.pll_mul_code       = q.pll_mul_code;
    ctx0.internal_full_rate = q.internal_full_rate;
    ctx0.ahb_code           = q.ahb_prescale_code;
    ctx0.apb1_code          = q.apb1_prescale_code;
    ctx0.apb2_code          = q.apb2_prescale_code;
    ctx0.adc_code           = q.adc_prescale_code;
    ctx0.xtal               = crystal_freq_hz;
  end

  // Prediv2: crystal divided by code plus one
  ctfc_div u_div_prediv2 (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (s_tvalid),
    .in_num    (DIV_W'(crystal_freq_hz)),
    .in_den    ({1'b0, q.prediv2_code} + DEN_W'(1)),
    .in_ctx    (ctx0),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_ctx   (d1_ctx)
  );

  // PLL2 multiply in half steps, then pick the prediv1 source
  always_comb begin
    pll2_prod   = d1_quo * FREQ_W'(pll2_mul_half(d1_ctx.pll2_mul_code));
    m1_num_next = d1_ctx.prediv1_from_pll2 ? (pll2_prod >> 1) : DIV_W'(d1_ctx.xtal);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (pipe_en) begin
      m1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m1_num <= m1_num_next;
      m1_ctx <= d1_ctx;
    end
  end

  // Prediv1: selected source divided by code plus one
  ctfc_div u_div_prediv1 (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (m1_valid),
    .in_num    (m1_num),
    .in_den    ({1'b0, m1_ctx.prediv1_code} + DEN_W'(1)),
    .in_ctx    (m1_ctx),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_ctx   (d2_ctx)
  );

  // Main PLL multiply (wraps at 32 bits before the halving) and system clock switch
  always_comb begin
    pll_base = d2_ctx.pll_from_prediv1 ? d2_quo :
               (d2_ctx.internal_full_rate ? HSI_HZ : HSI_HALF_HZ);
    pll_prod = pll_base * FREQ_W'(main_mul_half(d2_ctx.pll_mul_code));
    m2_ctx_next = d2_ctx;
    unique case (d2_ctx.sw)
      SW_HSI:  m2_ctx_next.sys = HSI_HZ;
      SW_HSE:  m2_ctx_next.sys = FREQ_W'(d2_ctx.xtal);
      SW_PLL:  m2_ctx_next.sys = pll_prod >> 1;
      SW_NONE: m2_ctx_next.sys = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (pipe_en) begin
      m2_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m2_ctx <= m2_ctx_next;
    end
  end

  ctfc_prescale u_prescale (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (m2_valid),
    .in_ctx    (m2_ctx),
    .out_valid (ps_valid),
    .out_ctx   (ps_ctx)
  );

  // ADC clock: APB2 divided by twice the code plus two
  ctfc_div u_div_adc (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (ps_valid),
    .in_num    (ps_ctx.apb2),
    .in_den    ({2'd0, ps_ctx.adc_code, 1'b0} + DEN_W'(2)),
    .in_ctx    (ps_ctx),
    .out_valid (d3_valid),
    .out_quo   (d3_quo),
    .out_ctx   (d3_ctx)
  );

  always_comb begin
    res                 = '0;
    res.system_freq     = d3_ctx.sys;
    res.ahb_freq        = d3_ctx.ahb;
    res.apb1_freq       = d3_ctx.apb1;
    res.apb1_timer_freq = d3_ctx.apb1t;
    res.apb2_freq       = d3_ctx.apb2;
    res.apb2_timer_freq = d3_ctx.apb2t;
    res.adc_freq        = d3_quo[ADC_W-1:0];
  end

  ctfc_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d3_valid),
    .in_data  (res),
    .en       (pipe_en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  assign m_res = result_t'(m_tdata);

  // A stalled pipeline means a result is waiting at the output
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |-> m_tvalid)
    else $error("pipeline stalled with no result on the output");

  // With no system clock every derived clock is stopped
  a_no_clock_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_res.system_freq == '0) |->
      (m_res.ahb_freq == '0 && m_res.apb1_freq == '0 && m_res.apb2_freq == '0 &&
       m_res.apb1_timer_freq == '0 && m_res.apb2_timer_freq == '0 && m_res.adc_freq == '0))
    else $error("derived clock nonzero while system clock is zero");

  // Prescalers only divide: each clock is at most its parent, timers at least the bus
  a_prescale_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (m_res.ahb_freq <= m_res.system_freq &&
       m_res.apb1_freq <= m_res.apb1_timer_freq && m_res.apb1_timer_freq <= m_res.ahb_freq &&
       m_res.apb2_freq <= m_res.apb2_timer_freq && m_res.apb2_timer_freq <= m_res.ahb_freq &&
       FREQ_W'(m_res.adc_freq) <= (m_res.apb2_freq >> 1)))
    else $error("prescaled clock ordering violated");

endmodule

`default_nettype wire

FILE: rtl/core/ctfc_div.sv
// Pipelined restoring divider: 32-bit dividend, small divisor, context carried alongside.
`default_nettype none

module ctfc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ctfc_pkg::DIV_W-1:0]    in_num,
  input  logic [ctfc_pkg::DEN_W-1:0]    in_den,
  input  ctfc_pkg::ctx_t                in_ctx,
  output logic                          out_valid,
  output logic [ctfc_pkg::DIV_W-1:0]    out_quo,
  output ctfc_pkg::ctx_t                out_ctx
);
  import ctfc_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] acc;
  } div_state_t;

  // Retire DIV_STEPS quotient bits: shift a dividend bit into the remainder, subtract if it fits
  function automatic div_state_t div_steps(input div_state_t s, input logic [DEN_W-1:0] den);
    div_state_t r;
    logic [DEN_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.acc[DIV_W-1]};
      r.acc = {r.acc[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        r.acc[0] = 1'b1;
      end
      r.rem = t[DEN_W-1:0];
    end
    return r;
  endfunction

  logic             st_valid [DIV_STAGES];
  div_state_t       st_q     [DIV_STAGES];
  logic [DEN_W-1:0] st_den   [DIV_STAGES];
  ctx_t             st_ctx   [DIV_STAGES];

  div_state_t       q_in     [DIV_STAGES];
  logic [DEN_W-1:0] den_in   [DIV_STAGES];
  ctx_t             ctx_in   [DIV_STAGES];

  always_comb begin
    q_in[0]   = div_state_t'{rem: '0, acc: in_num};
    den_in[0] = in_den;
    ctx_in[0] = in_ctx;
    for (int k = 1; k < DIV_STAGES; k++) begin
      q_in[k]   = st_q[k-1];
      den_in[k] = st_den[k-1];
      ctx_in[k] = st_ctx[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_valid[k] <= 1'b0;
      end
    end else if (en) begin
      st_valid[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_valid[k] <= st_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_q[k]   <= div_steps(q_in[k], den_in[k]);
        st_den[k] <= den_in[k];
        st_ctx[k] <= ctx_in[k];
      end
    end
  end

  assign out_valid = st_valid[DIV_STAGES-1];
  assign out_quo   = st_q[DIV_STAGES-1].acc;
  assign out_ctx   = st_ctx[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/ctfc_prescale.sv
// Bus prescalers: AHB shift in one stage, the four APB shifts in the next.
`default_nettype none

module ctfc_prescale (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ctfc_pkg::ctx_t in_ctx,
  output logic           out_valid,
  output ctfc_pkg::ctx_t out_ctx
);
  import ctfc_pkg::*;

  logic p1_valid;
  ctx_t p1_ctx;
  ctx_t p1_ctx_next;
  ctx_t p2_ctx_next;

  always_comb begin
    p1_ctx_next     = in_ctx;
    p1_ctx_next.ahb = in_ctx.sys >> ahb_shift(in_ctx.ahb_code);
  end

  always_comb begin
    p2_ctx_next       = p1_ctx;
    p2_ctx_next.apb1  = p1_ctx.ahb >> apb_shift(p1_ctx.apb1_code);
    p2_ctx_next.apb1t = p1_ctx.ahb >> apb_timer_shift(p1_ctx.apb1_code);
    p2_ctx_next.apb2  = p1_ctx.ahb >> apb_shift(p1_ctx.apb2_code);
    p2_ctx_next.apb2t = p1_ctx.ahb >> apb_timer_shift(p1_ctx.apb2_code);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= in_valid;
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ctx  <= p1_ctx_next;
      out_ctx <= p2_ctx_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ctfc_outbuf.sv
// Output register with a one-entry skid stage; stalls the pipeline only when the skid is full.
`default_nettype none

module ctfc_outbuf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  ctfc_pkg::result_t          in_data,
  output logic                       en,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ctfc_pkg::OUT_W-1:0] m_tdata
);
  import ctfc_pkg::*;

  logic    skid_valid;
  result_t skid;
  result_t out_data;
  logic    pop;
  logic    out_free;

  assign en       = !skid_valid;
  assign pop      = en && in_valid;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid   <= skid_valid || pop;
      skid_valid <= 1'b0;
    end else if (pop) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid : in_data;
    end else if (pop) begin
      skid <= in_data;
    end
  end

  assign m_tdata = out_data;

endmodule

`default_nettype wire
